>>> hw/rtl/fcfr_pkg.sv
// Shared types and constants for the command frame receiver.
`default_nettype none

package fcfr_pkg;

  // Command codes carried in frame byte 1
  localparam logic [7:0] CMD_SET_PID   = 8'h11;
  localparam logic [7:0] CMD_SET_ACCEL = 8'h12;

  // Action codes reported with each result beat
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PID     = 2'd1;
  localparam logic [1:0] ACT_ACCEL   = 2'd2;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  // Input kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_PROCESS = 1'b1;

  // Configuration register indexes (paddr[2])
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_END_BYTE   = 1'b1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Packed result tdata: byte_taken, frame_waiting, gains, accel, zero fill
  localparam int OUT_DW = 72;
  localparam int IN_DW  = 8;

  // Stored frame contents that the decoder needs, plus the pending flag
  typedef struct packed {
    logic        pending;
    logic [7:0]  cmd;
    logic [15:0] word_a;  // bytes 2-3
    logic [15:0] word_b;  // bytes 4-5
    logic [15:0] word_c;  // bytes 6-7
  } frame_view_t;

  // Per-beat status from the frame store
  typedef struct packed {
    logic taken;
    logic waiting;
  } step_status_t;

  // Decoded command fields
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] accel_value;
  } cmd_fields_t;

endpackage

`default_nettype wire

>>> hw/rtl/fcfr_frame.sv
// Frame store, fill count and pending flag of the command frame receiver.
`default_nettype none

module fcfr_frame #(
  parameter int FRAME_LEN = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 kind,
  input  wire logic [7:0]           data_byte,
  input  wire logic [7:0]           start_byte,
  input  wire logic [7:0]           end_byte,
  output fcfr_pkg::frame_view_t     view,
  output fcfr_pkg::step_status_t    status
);

  localparam int IW = $clog2(FRAME_LEN);

  logic [IW-1:0] fill;
  logic [IW-1:0] fill_next;
  logic          pending;
  logic          pending_next;
  logic          wr_en;
  logic          last_pos;
  logic [7:0]    store [FRAME_LEN];

  // Decide whether this byte enters the store and how the state moves
  always_comb begin
    wr_en        = 1'b0;
    fill_next    = fill;
    pending_next = pending;
    last_pos     = (fill == IW'(FRAME_LEN - 1));
    if (kind == fcfr_pkg::KIND_BYTE) begin
      if (!pending && ((fill == '0 && data_byte == start_byte) || fill != '0)) begin
        wr_en = 1'b1;
        if (last_pos) begin
          fill_next    = '0;
          pending_next = (data_byte == end_byte);
        end else begin
          fill_next = fill + IW'(1);
        end
      end
    end else begin
      // A process request consumes the pending frame
      pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      pending <= 1'b0;
    end else if (step) begin
      fill    <= fill_next;
      pending <= pending_next;
    end
  end

  // Store the byte at the fill position
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      store[fill] <= data_byte;
    end
  end

  assign view.pending = pending;
  assign view.cmd     = store[1];
  assign view.word_a  = {store[2], store[3]};
  assign view.word_b  = {store[4], store[5]};
  assign view.word_c  = {store[6], store[7]};

  assign status.taken   = wr_en;
  assign status.waiting = pending_next;

endmodule

`default_nettype wire

>>> hw/rtl/fcfr_decode.sv
// Command decoder: turns a pending frame into action and value fields.
`default_nettype none

module fcfr_decode (
  input  wire logic                  kind,
  input  fcfr_pkg::frame_view_t      view,
  output fcfr_pkg::cmd_fields_t      fields
);

  always_comb begin
    fields = '0;
    if (kind == fcfr_pkg::KIND_PROCESS && view.pending) begin
      case (view.cmd)
        fcfr_pkg::CMD_SET_PID: begin
          fields.action = fcfr_pkg::ACT_PID;
          fields.gain_p = view.word_a;
          fields.gain_i = view.word_b;
          fields.gain_d = view.word_c;
        end
        fcfr_pkg::CMD_SET_ACCEL: begin
          fields.action      = fcfr_pkg::ACT_ACCEL;
          fields.accel_value = view.word_a;
        end
        default: begin
          fields.action = fcfr_pkg::ACT_UNKNOWN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fixed_length_command_frame_receiver_core.sv
// Top level of the fixed-length command frame receiver.
//
//   Channel  Dir  Handshake                 Payload
//   s_*      in   s_tvalid/s_tready         tdata: data_byte; tuser: kind
//   m_*      out  m_tvalid/m_tready         tdata: flags, gains, accel; tuser: action
//   APB      in   psel/penable/pwrite       start_byte (0x0), end_byte (0x4)
//
// One beat per cycle sustained while m_* does not stall; each beat passes from s_* to m_*
// through the input register, then the result register. Synchronous active-high reset
// clears fill count, pending flag and both valid flags; the frame store is
// not cleared. A stall on m_* holds the result; s_tready stays high while
// the input register is empty, so one beat is taken during a stall.
`default_nettype none

module fixed_length_command_frame_receiver_core #(
  parameter int FRAME_LEN = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [fcfr_pkg::IN_DW-1:0]   s_tdata,   // [7:0] data_byte
  input  wire logic                         s_tuser,   // [0] kind
  // Result stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [0] byte_taken, [1] frame_waiting, [17:2] gain_p, [33:18] gain_i,
  // [49:34] gain_d, [65:50] accel_value, [71:66] zero
  output logic [fcfr_pkg::OUT_DW-1:0]       m_tdata,
  output logic [1:0]                        m_tuser,   // [1:0] action
  // Configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fcfr_pkg::APB_AW-1:0]  paddr,
  input  wire logic [fcfr_pkg::APB_DW-1:0]  pwdata,
  output logic [fcfr_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  logic       start_byte;
  logic [7:0] start_val;
  logic [7:0] end_val;
  logic       cfg_wr;

  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;

  fcfr_pkg::frame_view_t  view;
  fcfr_pkg::step_status_t status;
  fcfr_pkg::cmd_fields_t  fields;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign start_byte = (paddr[2] == fcfr_pkg::REG_START_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_val <= 8'd0;
      end_val   <= 8'd0;
    end else if (cfg_wr) begin
      if (start_byte) begin
        start_val <= pwdata[7:0];
      end else begin
        end_val <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      fcfr_pkg::REG_START_BYTE: prdata[7:0] = start_val;
      fcfr_pkg::REG_END_BYTE:   prdata[7:0] = end_val;
      default:                  prdata      = '0;
    endcase
  end

  // Pipeline control: advance when the result register is free or drains
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_byte <= s_tdata[7:0];
    end
  end

  fcfr_frame #(
    .FRAME_LEN (FRAME_LEN)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .kind       (in_kind),
    .data_byte  (in_byte),
    .start_byte (start_val),
    .end_byte   (end_val),
    .view       (view),
    .status     (status)
  );

  fcfr_decode u_decode (
    .kind   (in_kind),
    .view   (view),
    .fields (fields)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {6'd0, fields.accel_value, fields.gain_d, fields.gain_i,
                  fields.gain_p, status.waiting, status.taken};
      m_tuser <= fields.action;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fcfr_checker.sv
// Port-level checks for the command frame receiver, bound to the top level.
`default_nettype none

module fcfr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [fcfr_pkg::OUT_DW-1:0]  m_tdata,
  input wire logic [1:0]                   m_tuser
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Input side only stalls while a result is waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled with free result register");

  // A decoded command never accompanies a stored byte or a still-pending frame
  a_action_flags: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != fcfr_pkg::ACT_NONE) |-> (m_tdata[1:0] == 2'b00))
    else $error("action with byte_taken or frame_waiting set");

  // Gain and acceleration fields are zero outside their actions
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != fcfr_pkg::ACT_PID && m_tuser != fcfr_pkg::ACT_ACCEL)
      |-> (m_tdata[65:2] == '0))
    else $error("value fields nonzero without a command");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind fixed_length_command_frame_receiver_core fcfr_checker u_fcfr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

>>> sim/tb_fixed_length_command_frame_receiver_core.sv
// Self-checking testbench for the fixed-length command frame receiver core.
`timescale 1ns / 1ps

module tb_fixed_length_command_frame_receiver_core;

  localparam int FRAME_LEN   = 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic        taken;
    logic        waiting;
    logic [1:0]  action;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] accel;
  } frame_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [fcfr_pkg::IN_DW-1:0]   s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [fcfr_pkg::OUT_DW-1:0]  m_tdata;
  logic [1:0]                   m_tuser;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [fcfr_pkg::APB_AW-1:0]  paddr = '0;
  logic [fcfr_pkg::APB_DW-1:0]  pwdata = '0;
  logic [fcfr_pkg::APB_DW-1:0]  prdata;
  logic                         pready;

  fixed_length_command_frame_receiver_core #(
    .FRAME_LEN(FRAME_LEN)
  ) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Stimulus and expectation stores
  rx_item_t      beat_q[$];
  frame_result_t result_q[$];
  int            err_cnt = 0;
  int            cycle_cnt = 0;
  bit            no_idle = 1'b0;
  int            src_gap = 0;
  int            sink_stall = 0;

  // Receiver mirror: configuration and frame state
  logic [7:0]    cfg_start = 8'h00;
  logic [7:0]    cfg_end = 8'h00;
  int            fill_cnt = 0;
  logic [7:0]    frame_buf [FRAME_LEN];
  bit            frame_pend = 1'b0;

  // Advance the receiver mirror by one beat and return what it reports
  function automatic frame_result_t receive_beat(input rx_item_t it);
    frame_result_t r;
    r = '0;
    if (it.kind == fcfr_pkg::KIND_BYTE) begin
      if (!frame_pend) begin
        if (fill_cnt >= FRAME_LEN) fill_cnt = 0;
        if (fill_cnt != 0 || it.data == cfg_start) begin
          frame_buf[fill_cnt] = it.data;
          fill_cnt++;
          r.taken = 1'b1;
          if (fill_cnt >= FRAME_LEN) begin
            fill_cnt = 0;
            if (frame_buf[FRAME_LEN-1] == cfg_end) frame_pend = 1'b1;
          end
        end
      end
    end else if (frame_pend) begin
      case (frame_buf[1])
        fcfr_pkg::CMD_SET_PID: begin
          r.action = fcfr_pkg::ACT_PID;
          r.gain_p = {frame_buf[2], frame_buf[3]};
          r.gain_i = {frame_buf[4], frame_buf[5]};
          r.gain_d = {frame_buf[6], frame_buf[7]};
        end
        fcfr_pkg::CMD_SET_ACCEL: begin
          r.action = fcfr_pkg::ACT_ACCEL;
          r.accel  = {frame_buf[2], frame_buf[3]};
        end
        default: r.action = fcfr_pkg::ACT_UNKNOWN;
      endcase
      frame_pend = 1'b0;
    end
    r.waiting = frame_pend;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none in burst stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %0h, want %0h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_fixed_length_command_frame_receiver_core: errors");
      $finish;
    end
  end

  // Input driver: predict on acceptance, then load the next beat or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        result_q.push_back(receive_beat('{kind: s_tuser, data: s_tdata}));
      end
      if (src_gap > 0) begin
        src_gap  <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tuser  <= beat_q[0].kind;
        s_tdata  <= beat_q[0].data;
        void'(beat_q.pop_front());
        src_gap  <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: random backpressure, compare against oldest expectation
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("unexpected result beat at cycle %0d", cycle_cnt);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (m_tdata[0] !== want.taken)
            report("byte_taken", 16'(m_tdata[0]), 16'(want.taken));
          if (m_tdata[1] !== want.waiting)
            report("frame_waiting", 16'(m_tdata[1]), 16'(want.waiting));
          if (m_tuser !== want.action)
            report("action", 16'(m_tuser), 16'(want.action));
          if (m_tdata[17:2] !== want.gain_p) report("gain_p", m_tdata[17:2], want.gain_p);
          if (m_tdata[33:18] !== want.gain_i) report("gain_i", m_tdata[33:18], want.gain_i);
          if (m_tdata[49:34] !== want.gain_d) report("gain_d", m_tdata[49:34], want.gain_d);
          if (m_tdata[65:50] !== want.accel) report("accel_value", m_tdata[65:50], want.accel);
        end
      end
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready   <= 1'b1;
        sink_stall <= pick_gap();
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    beat_q.push_back('{kind: fcfr_pkg::KIND_BYTE, data: b});
  endtask

  task automatic push_req();
    beat_q.push_back('{kind: fcfr_pkg::KIND_PROCESS, data: 8'($urandom)});
  endtask

  // Start byte, command, seven body bytes (bytes 2..8, high first), last byte
  task automatic push_frame(input logic [7:0] cmd, input logic [55:0] body,
                            input logic [7:0] last);
    push_byte(cfg_start);
    push_byte(cmd);
    for (int i = 6; i >= 0; i--) push_byte(body[i*8 +: 8]);
    push_byte(last);
  endtask

  // One register write: setup cycle, then access cycle
  task automatic apb_write(input logic idx, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), value} & 32'h0000_00FF | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == fcfr_pkg::REG_START_BYTE) cfg_start = value;
    else cfg_end = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold until every beat has gone in and every result has come out
  task automatic drain();
    @(negedge clk);
    while (beat_q.size() > 0 || result_q.size() > 0 || s_tvalid) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly well-formed frames with random content, some noise and broken frames
  task automatic gen_traffic(input int n);
    int start_sz;
    int r;
    logic [7:0] cmd;
    start_sz = beat_q.size();
    while (beat_q.size() - start_sz < n) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cmd = fcfr_pkg::CMD_SET_PID;
          4, 5, 6:    cmd = fcfr_pkg::CMD_SET_ACCEL;
          default:    cmd = 8'($urandom);
        endcase
        push_frame(cmd, 56'({$urandom, $urandom}),
                   ($urandom_range(0, 99) < 85) ? cfg_end : 8'($urandom));
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom));
        if ($urandom_range(0, 9) < 7) push_req();
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end else if (r < 90) begin
        push_req();
      end else begin
        push_byte(cfg_start);
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
      end
    end
  endtask

  // Test sequence
  initial begin
    logic [7:0] phase_start [4];
    logic [7:0] phase_end [4];
    phase_start = '{8'h00, 8'hFF, 8'($urandom), 8'h7E};
    phase_end   = '{8'hFF, 8'h00, 8'($urandom), 8'h7E};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apb_write(fcfr_pkg::REG_START_BYTE, 8'hA5);
    apb_write(fcfr_pkg::REG_END_BYTE, 8'h5A);

    // Directed: idle request, ignored bytes, PID frame, drop while pending
    @(negedge clk);
    push_req();
    push_byte(8'h00);
    push_frame(fcfr_pkg::CMD_SET_PID, 56'hFFFF_0000_1234_00, 8'h5A);
    push_byte(8'hA5);
    push_req();
    push_req();
    // Directed: request mid-frame leaves the partial frame filling
    push_byte(8'hA5);
    push_byte(fcfr_pkg::CMD_SET_ACCEL);
    push_byte(8'h80);
    push_byte(8'h01);
    push_req();
    for (int i = 0; i < 5; i++) push_byte(8'h3C);
    push_byte(8'h5A);
    push_req();
    drain();

    // Random phases over several register settings, with a full pause midway
    for (int p = 0; p < 4; p++) begin
      apb_write(fcfr_pkg::REG_START_BYTE, phase_start[p]);
      apb_write(fcfr_pkg::REG_END_BYTE, phase_end[p]);
      @(negedge clk);
      no_idle = (p == 2);
      gen_traffic(50);
      drain();
      no_idle = 1'b0;
      gen_traffic(50);
      drain();
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_fixed_length_command_frame_receiver_core: clean");
    end else begin
      $display("tb_fixed_length_command_frame_receiver_core: errors");
    end
    $finish;
  end

endmodule
